// File: design/lztd_pkg.sv
// Shared types and constants for the LZ77 token decompressor.
// No dependencies; used by lz77_token_decompressor_core.
package lztd_pkg;

  // Window geometry
  localparam int WINDOW_DEPTH = 4096;

  // Token word that opens a back-reference
  localparam logic [15:0] MARKER_WORD = 16'h7fff;

  // Back-reference length is the low nibble plus this bias
  localparam int LEN_BIAS = 4;

  // Input request
  typedef struct packed {
    logic [15:0] token;
    logic        end_of_block;
  } in_item_t;

  // Output request
  typedef struct packed {
    logic [7:0]  out_byte;
    logic        last_of_run;
    logic [31:0] produced_count;
  } out_item_t;

endpackage

// File: design/lztd_ram.sv
// Generic single-clock RAM: one write port, one read port, registered read data.
// No dependencies.
module lztd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port; read returns the old contents on a same-address collision
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

// File: design/lz77_token_decompressor_core.sv
// LZ77 token decompressor top level: token parser, copy sequencer and output queue.
// Depends on lztd_pkg and lztd_ram (history window).
//
// Takes one 16-bit token word per request and returns decompressed bytes. A literal,
// a marker word or a reference high word is accepted and leaves the block idle; a literal gives
// one byte, a marker or high word gives none. A reference low word gives 4 to 19
// bytes, one per cycle while the output queue has room, and no next word is taken
// until the last of them is issued. The rate is set by the single read port of the
// 4096-byte history window: every copied byte is one window read. Window read data
// is registered; a distance-one copy takes the previous byte from a local register.
// The window needs no clearing pass after reset: a fill count marks which slots
// have been written, and a read of an unwritten slot returns zero. A two-entry
// output queue lets copying continue while a result waits to be taken.
module lz77_token_decompressor_core #(
  parameter int WINDOW_DEPTH = lztd_pkg::WINDOW_DEPTH
) (
  input  logic                clk,
  input  logic                rst_n,
  // input channel
  input  logic                in_valid,
  output logic                in_stall,
  input  lztd_pkg::in_item_t  in_item,
  // result channel
  output logic                out_valid,
  input  logic                out_stall,
  output lztd_pkg::out_item_t out_item
);

  localparam int AW = $clog2(WINDOW_DEPTH);
  localparam int DW = AW + 1;
  localparam logic [DW-1:0] FILL_MAX = DW'(WINDOW_DEPTH);

  typedef enum logic [0:0] {ST_IDLE, ST_COPY} state_t;
  typedef enum logic [1:0] {PH_LIT, PH_HIGH, PH_LOW} phase_t;

  state_t      state_r;
  phase_t      phase_r;
  logic [7:0]  saved_high_r;
  logic [AW-1:0] wp_r;
  logic [DW-1:0] fill_r;
  logic [31:0] cnt_r;
  logic [DW-1:0] dist_r;
  logic [4:0]  rem_r;
  logic        eob_r;

  // byte stage (window read in flight or literal)
  logic          b_pend_r;
  logic          b_lit_r;
  logic          b_zero_r;
  logic          b_fwd_r;
  logic [7:0]    b_val_r;
  logic          b_last_r;
  logic [31:0]   b_cnt_r;
  logic [AW-1:0] b_addr_r;
  logic [7:0]    last_byte_r;

  // output queue
  logic                out_valid_r;
  lztd_pkg::out_item_t out_item_r;
  logic                skid_valid_r;
  lztd_pkg::out_item_t skid_item_r;

  logic [1:0]    occ;
  logic          pop;
  logic          slot_ok;
  logic          acc;
  logic          copy_iss;
  logic          is_marker;
  logic [AW-1:0] rd_addr;
  logic [7:0]    ram_rdata;
  logic [7:0]    b_byte;
  lztd_pkg::out_item_t b_item;
  logic [DW-1:0] dist_new;
  logic [31:0]   cnt_inc;
  logic [DW-1:0] fill_inc;

  // Room check: queue plus byte stage never exceed two
  assign occ     = {1'b0, out_valid_r} + {1'b0, skid_valid_r} + {1'b0, b_pend_r};
  assign pop     = out_valid_r & ~out_stall;
  assign slot_ok = (occ != 2'd2) | pop;

  assign in_stall  = !((state_r == ST_IDLE) && slot_ok);
  assign acc       = in_valid & ~in_stall;
  assign copy_iss  = (state_r == ST_COPY) && slot_ok;
  assign is_marker = (in_item.token == lztd_pkg::MARKER_WORD);

  // Source slot, distance, counters
  assign rd_addr  = wp_r - dist_r[AW-1:0];
  assign dist_new = DW'({saved_high_r, in_item.token[7:4]}) + DW'(1);
  assign cnt_inc  = cnt_r + 32'd1;
  assign fill_inc = (fill_r == FILL_MAX) ? fill_r : fill_r + DW'(1);

  // Byte selection at the window read return
  always_comb begin
    if (b_lit_r) begin
      b_byte = b_val_r;
    end else if (b_zero_r) begin
      b_byte = 8'd0;
    end else if (b_fwd_r) begin
      b_byte = last_byte_r;
    end else begin
      b_byte = ram_rdata;
    end
    b_item.out_byte       = b_byte;
    b_item.last_of_run    = b_last_r;
    b_item.produced_count = b_cnt_r;
  end

  lztd_ram #(
    .WIDTH (8),
    .DEPTH (WINDOW_DEPTH)
  ) u_window (
    .clk   (clk),
    .we    (b_pend_r),
    .waddr (b_addr_r),
    .wdata (b_byte),
    .raddr (rd_addr),
    .rdata (ram_rdata)
  );

  // Parser, copy sequencer, byte stage and output queue
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      phase_r      <= PH_LIT;
      saved_high_r <= 8'd0;
      wp_r         <= '0;
      fill_r       <= '0;
      cnt_r        <= 32'd0;
      b_pend_r     <= 1'b0;
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      b_pend_r <= 1'b0;

      // accepted token word
      if (acc) begin
        unique case (phase_r)
          PH_HIGH: begin
            saved_high_r <= in_item.token[7:0];
            phase_r      <= PH_LOW;
          end
          PH_LOW: begin
            dist_r  <= dist_new;
            rem_r   <= 5'(in_item.token[3:0]) + 5'(lztd_pkg::LEN_BIAS - 1);
            eob_r   <= in_item.end_of_block;
            state_r <= ST_COPY;
            phase_r <= PH_LIT;
          end
          default: begin
            if (is_marker) begin
              phase_r <= PH_HIGH;
            end else begin
              // literal goes straight to the byte stage
              b_pend_r <= 1'b1;
              b_lit_r  <= 1'b1;
              b_zero_r <= 1'b0;
              b_fwd_r  <= 1'b0;
              b_val_r  <= in_item.token[7:0];
              b_last_r <= 1'b1;
              b_cnt_r  <= cnt_inc;
              b_addr_r <= wp_r;
              wp_r     <= wp_r + AW'(1);
              fill_r   <= fill_inc;
              cnt_r    <= cnt_inc;
              phase_r  <= PH_LIT;
            end
          end
        endcase
        if (in_item.end_of_block) begin
          phase_r      <= PH_LIT;
          saved_high_r <= 8'd0;
          if (phase_r != PH_LOW) begin
            cnt_r <= 32'd0;
          end
        end
      end

      // one copied byte per cycle while the queue has room: issue window read
      if (copy_iss) begin
        b_pend_r <= 1'b1;
        b_lit_r  <= 1'b0;
        b_zero_r <= (dist_r > fill_r);
        b_fwd_r  <= (dist_r == DW'(1));
        b_val_r  <= 8'd0;
        b_last_r <= (rem_r == 5'd0);
        b_cnt_r  <= cnt_inc;
        b_addr_r <= wp_r;
        wp_r     <= wp_r + AW'(1);
        fill_r   <= fill_inc;
        cnt_r    <= cnt_inc;
        rem_r    <= rem_r - 5'd1;
        if (rem_r == 5'd0) begin
          state_r <= ST_IDLE;
          if (eob_r) begin
            cnt_r <= 32'd0;
          end
        end
      end

      // byte stage retires into the queue
      if (b_pend_r) begin
        last_byte_r <= b_byte;
      end

      if (!out_valid_r || pop) begin
        if (skid_valid_r) begin
          out_item_r   <= skid_item_r;
          out_valid_r  <= 1'b1;
          skid_item_r  <= b_item;
          skid_valid_r <= b_pend_r;
        end else begin
          out_item_r  <= b_item;
          out_valid_r <= b_pend_r;
        end
      end else if (b_pend_r) begin
        skid_item_r  <= b_item;
        skid_valid_r <= 1'b1;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule
